### sv/rfd_pkg.sv
// Package for the reply frame deframer: payload types, phase codes, error codes, constants.
package rfd_pkg;

   localparam logic [7:0]  MAGIC_FIRST   = 8'hcd;
   localparam logic [7:0]  MAGIC_SECOND  = 8'h68;
   localparam logic [15:0] DEFAULT_LIMIT = 16'h0110;
   localparam logic [31:0] CRC_POLY      = 32'hedb88320;
   localparam logic [15:0] CRC_BYTES     = 16'd4;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic CSR_MAX_LENGTH = 1'b0;
   localparam logic CSR_REPLY_MAX  = 1'b1;

   localparam logic [2:0] ERR_OK     = 3'd0;
   localparam logic [2:0] ERR_NODATA = 3'd1;
   localparam logic [2:0] ERR_MAGIC  = 3'd2;
   localparam logic [2:0] ERR_LONG   = 3'd3;
   localparam logic [2:0] ERR_CRC    = 3'd4;
   localparam logic [2:0] ERR_TRUNC  = 3'd5;

   typedef enum logic [2:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_STATUS,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAYLOAD,
      PH_CRC,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [2:0]  error_code;
      logic [7:0]  device_status;
      logic [15:0] frame_length;
   } rsp_type;

endpackage

### sv/rfd_crc_step.sv
// One-byte update of the complemented reflected CRC-32 accumulator.
module rfd_crc_step (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] c;
      c = ~crc_cur ^ {24'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ rfd_pkg::CRC_POLY) : (c >> 1);
      end
      crc_next = ~c;
   end

endmodule

### sv/reply_frame_deframer_crc32_core.sv
// Reply frame deframer: magic, status, length, payload, CRC-32 check and completion report.
//
//   port group   dir   handshake               payload
//   req_         in    req_valid / req_ready   req_data  (rfd_pkg::req_type)
//   rsp_         out   rsp_valid / rsp_ready   rsp_data  (rfd_pkg::rsp_type)
//   csr_         in    csr_write               csr_index, csr_wdata
//
// One request per cycle while req_ready is high; its result (if any) is in the output register the next cycle.
// The frame state and CRC update sit between the request handshake and the output register.
// req_ready drops only while a result waits in the output register and rsp_ready is low.
// Synchronous reset clears the frame state and loads 0x110 into both limit registers.
module reply_frame_deframer_crc32_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rfd_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   rfd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        crc_ff, crc_in, crc_next;
   logic [15:0]        len_ff, len_in;
   logic [15:0]        cnt_ff, cnt_in, cnt_plus;
   logic [7:0]         status_ff, status_in;
   logic [31:0]        rcrc_ff, rcrc_in, rcrc_shift;
   logic [2:0]         perr_ff, perr_in;
   logic [15:0]        max_length_ff, reply_max_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rfd_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               req_fire, emit, done;
   logic [2:0]         done_err;

   rfd_crc_step u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_data.rx_byte),
      .crc_next  (crc_next)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign cnt_plus   = cnt_ff + 16'd1;
   assign rcrc_shift = {rcrc_ff[23:0], req_data.rx_byte};

   always_comb begin
      phase_in    = phase_ff;
      crc_in      = crc_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      rcrc_in     = rcrc_ff;
      perr_in     = perr_ff;
      emit        = 1'b0;
      done        = 1'b0;
      done_err    = rfd_pkg::ERR_OK;
      rsp_data_in = '0;
      rsp_data_in.device_status = status_ff;
      rsp_data_in.frame_length  = len_ff;
      if (req_fire) begin
         if (req_data.operation == rfd_pkg::OP_TIMEOUT) begin
            done = 1'b1;
            if (phase_ff == rfd_pkg::PH_MAGIC0) begin
               done_err = rfd_pkg::ERR_NODATA;
            end else if (phase_ff == rfd_pkg::PH_DISCARD) begin
               done_err = perr_ff;
            end else begin
               done_err = rfd_pkg::ERR_TRUNC;
            end
         end else begin
            case (phase_ff)
               rfd_pkg::PH_MAGIC0: begin
                  crc_in    = '0;
                  len_in    = '0;
                  cnt_in    = '0;
                  status_in = '0;
                  rcrc_in   = '0;
                  if (req_data.rx_byte == rfd_pkg::MAGIC_FIRST) begin
                     perr_in  = rfd_pkg::ERR_OK;
                     phase_in = rfd_pkg::PH_MAGIC1;
                  end else begin
                     perr_in  = rfd_pkg::ERR_MAGIC;
                     phase_in = rfd_pkg::PH_DISCARD;
                  end
               end
               rfd_pkg::PH_MAGIC1: begin
                  if (req_data.rx_byte == rfd_pkg::MAGIC_SECOND) begin
                     phase_in = rfd_pkg::PH_STATUS;
                  end else begin
                     perr_in  = rfd_pkg::ERR_MAGIC;
                     phase_in = rfd_pkg::PH_DISCARD;
                  end
               end
               rfd_pkg::PH_STATUS: begin
                  status_in = req_data.rx_byte;
                  crc_in    = crc_next;
                  phase_in  = rfd_pkg::PH_LEN_HI;
               end
               rfd_pkg::PH_LEN_HI: begin
                  len_in   = {req_data.rx_byte, 8'd0};
                  crc_in   = crc_next;
                  phase_in = rfd_pkg::PH_LEN_LO;
               end
               rfd_pkg::PH_LEN_LO: begin
                  len_in = {len_ff[15:8], req_data.rx_byte};
                  crc_in = crc_next;
                  cnt_in = '0;
                  if (len_in > max_length_ff) begin
                     perr_in  = rfd_pkg::ERR_LONG;
                     phase_in = rfd_pkg::PH_DISCARD;
                  end else if (len_in == 16'd0) begin
                     phase_in = rfd_pkg::PH_CRC;
                  end else begin
                     phase_in = rfd_pkg::PH_PAYLOAD;
                  end
               end
               rfd_pkg::PH_PAYLOAD: begin
                  crc_in = crc_next;
                  if (cnt_ff < reply_max_ff) begin
                     emit                     = 1'b1;
                     rsp_data_in.kind         = rfd_pkg::KIND_BYTE;
                     rsp_data_in.payload_byte = req_data.rx_byte;
                     rsp_data_in.byte_index   = cnt_ff;
                     rsp_data_in.error_code   = rfd_pkg::ERR_OK;
                  end
                  if (cnt_plus >= len_ff) begin
                     cnt_in   = '0;
                     phase_in = rfd_pkg::PH_CRC;
                  end else begin
                     cnt_in = cnt_plus;
                  end
               end
               rfd_pkg::PH_CRC: begin
                  rcrc_in = rcrc_shift;
                  if (cnt_plus >= rfd_pkg::CRC_BYTES) begin
                     cnt_in = '0;
                     if (rcrc_shift == crc_ff) begin
                        done     = 1'b1;
                        done_err = rfd_pkg::ERR_OK;
                     end else begin
                        perr_in  = rfd_pkg::ERR_CRC;
                        phase_in = rfd_pkg::PH_DISCARD;
                     end
                  end else begin
                     cnt_in = cnt_plus;
                  end
               end
               rfd_pkg::PH_DISCARD: begin
                  phase_in = rfd_pkg::PH_DISCARD;
               end
               default: begin
                  phase_in = rfd_pkg::PH_DISCARD;
               end
            endcase
         end
         if (done) begin
            emit                      = 1'b1;
            rsp_data_in               = '0;
            rsp_data_in.kind          = rfd_pkg::KIND_DONE;
            rsp_data_in.error_code    = done_err;
            rsp_data_in.device_status = status_ff;
            rsp_data_in.frame_length  = len_ff;
            phase_in  = rfd_pkg::PH_MAGIC0;
            crc_in    = '0;
            len_in    = '0;
            cnt_in    = '0;
            status_in = '0;
            rcrc_in   = '0;
            perr_in   = rfd_pkg::ERR_OK;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rfd_pkg::PH_MAGIC0;
         crc_ff        <= '0;
         len_ff        <= '0;
         cnt_ff        <= '0;
         status_ff     <= '0;
         rcrc_ff       <= '0;
         perr_ff       <= rfd_pkg::ERR_OK;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= rfd_pkg::DEFAULT_LIMIT;
         reply_max_ff  <= rfd_pkg::DEFAULT_LIMIT;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rcrc_ff      <= rcrc_in;
         perr_ff      <= perr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_index == rfd_pkg::CSR_MAX_LENGTH) begin
            max_length_ff <= csr_wdata;
         end
         if (csr_write && csr_index == rfd_pkg::CSR_REPLY_MAX) begin
            reply_max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == rfd_pkg::KIND_BYTE
      |-> rsp_data_ff.error_code == rfd_pkg::ERR_OK && rsp_data_ff.byte_index < reply_max_ff)
      else $error("payload request result out of range");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      done |=> phase_ff == rfd_pkg::PH_MAGIC0 && crc_ff == 32'd0 && len_ff == 16'd0)
      else $error("frame state not cleared after completion");

   a_discard_err: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rfd_pkg::PH_DISCARD
      |-> perr_ff == rfd_pkg::ERR_MAGIC || perr_ff == rfd_pkg::ERR_LONG
          || perr_ff == rfd_pkg::ERR_CRC)
      else $error("discard without a pending error");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result overwritten while stalled");

endmodule

### tb/sv/testbench.sv
// Testbench for the reply frame deframer: directed and random frames checked by a frame predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_LIMIT = 60;

   class deframe_scoreboard;
      logic [15:0]         length_limit;
      logic [15:0]         keep_limit;
      rfd_pkg::phase_type  phase;
      logic [31:0]         crc_acc;
      logic [31:0]         crc_seen;
      logic [15:0]         length_seen;
      logic [15:0]         count;
      logic [7:0]          status_seen;
      logic [2:0]          held_error;
      rfd_pkg::rsp_type    replies_due[$];
      int                  mismatches;

      function new();
         length_limit = rfd_pkg::DEFAULT_LIMIT;
         keep_limit   = rfd_pkg::DEFAULT_LIMIT;
         mismatches   = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase       = rfd_pkg::PH_MAGIC0;
         crc_acc     = '0;
         crc_seen    = '0;
         length_seen = '0;
         count       = '0;
         status_seen = '0;
         held_error  = rfd_pkg::ERR_OK;
      endfunction

      function void set_limits(logic [15:0] len_max, logic [15:0] keep_max);
         length_limit = len_max;
         keep_limit   = keep_max;
      endfunction

      // CRC-32 kept complemented, so zero is the all-ones preset
      function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] data);
         logic [31:0] c;
         c = ~acc ^ {24'd0, data};
         for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ rfd_pkg::CRC_POLY) : (c >> 1);
         return ~c;
      endfunction

      function void finish_frame(logic [2:0] code);
         rfd_pkg::rsp_type r;
         r = '0;
         r.kind          = rfd_pkg::KIND_DONE;
         r.error_code    = code;
         r.device_status = status_seen;
         r.frame_length  = length_seen;
         replies_due.push_back(r);
         clear_frame();
      endfunction

      function void take_request(rfd_pkg::req_type req);
         rfd_pkg::rsp_type r;
         logic [7:0]       b;
         b = req.rx_byte;
         if (req.operation == rfd_pkg::OP_TIMEOUT) begin
            if (phase == rfd_pkg::PH_MAGIC0)
               finish_frame(rfd_pkg::ERR_NODATA);
            else if (phase == rfd_pkg::PH_DISCARD)
               finish_frame(held_error);
            else
               finish_frame(rfd_pkg::ERR_TRUNC);
            return;
         end
         case (phase)
            rfd_pkg::PH_MAGIC0: begin
               if (b == rfd_pkg::MAGIC_FIRST) begin
                  phase = rfd_pkg::PH_MAGIC1;
               end else begin
                  phase      = rfd_pkg::PH_DISCARD;
                  held_error = rfd_pkg::ERR_MAGIC;
               end
            end
            rfd_pkg::PH_MAGIC1: begin
               if (b == rfd_pkg::MAGIC_SECOND) begin
                  phase = rfd_pkg::PH_STATUS;
               end else begin
                  phase      = rfd_pkg::PH_DISCARD;
                  held_error = rfd_pkg::ERR_MAGIC;
               end
            end
            rfd_pkg::PH_STATUS: begin
               status_seen = b;
               crc_acc     = crc_step(crc_acc, b);
               phase       = rfd_pkg::PH_LEN_HI;
            end
            rfd_pkg::PH_LEN_HI: begin
               length_seen = {b, 8'h00};
               crc_acc     = crc_step(crc_acc, b);
               phase       = rfd_pkg::PH_LEN_LO;
            end
            rfd_pkg::PH_LEN_LO: begin
               length_seen[7:0] = b;
               crc_acc          = crc_step(crc_acc, b);
               count            = '0;
               if (length_seen > length_limit) begin
                  phase      = rfd_pkg::PH_DISCARD;
                  held_error = rfd_pkg::ERR_LONG;
               end else if (length_seen == 16'd0) begin
                  phase = rfd_pkg::PH_CRC;
               end else begin
                  phase = rfd_pkg::PH_PAYLOAD;
               end
            end
            rfd_pkg::PH_PAYLOAD: begin
               crc_acc = crc_step(crc_acc, b);
               if (count < keep_limit) begin
                  r               = '0;
                  r.kind          = rfd_pkg::KIND_BYTE;
                  r.payload_byte  = b;
                  r.byte_index    = count;
                  r.device_status = status_seen;
                  r.frame_length  = length_seen;
                  replies_due.push_back(r);
               end
               count = count + 16'd1;
               if (count >= length_seen) begin
                  count = '0;
                  phase = rfd_pkg::PH_CRC;
               end
            end
            rfd_pkg::PH_CRC: begin
               crc_seen = {crc_seen[23:0], b};
               count    = count + 16'd1;
               if (count >= rfd_pkg::CRC_BYTES) begin
                  count = '0;
                  if (crc_seen == crc_acc) begin
                     finish_frame(rfd_pkg::ERR_OK);
                  end else begin
                     phase      = rfd_pkg::PH_DISCARD;
                     held_error = rfd_pkg::ERR_CRC;
                  end
               end
            end
            default: phase = rfd_pkg::PH_DISCARD;
         endcase
      endfunction

      task log_mismatch(string what);
         if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_reply(rfd_pkg::rsp_type got);
         rfd_pkg::rsp_type want;
         if (replies_due.size() == 0) begin
            log_mismatch($sformatf("reply %h with none outstanding", got));
            return;
         end
         want = replies_due.pop_front();
         if (got !== want)
            log_mismatch($sformatf("reply got %h want %h", got, want));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rfd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rfd_pkg::rsp_type rsp_data;
   logic             csr_write;
   logic             csr_index;
   logic [15:0]      csr_wdata;

   bit          idling       = 1'b1;
   bit          hold_request = 1'b0;
   int          cycles       = 0;
   int          sent_items   = 0;
   logic [7:0]  frame_q[$];
   deframe_scoreboard board;

   reply_frame_deframer_crc32_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_reply(rsp_data);
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14)
         return $urandom_range(1, 3);
      if (r < 19)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_length()) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic op, input logic [7:0] data);
      rfd_pkg::req_type item;
      item.operation = op;
      item.rx_byte   = data;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      board.take_request(item);
      sent_items++;
      @(negedge clock);
      if (idling && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(negedge clock);
      end
   endtask

   task automatic send_timeout();
      send_request(rfd_pkg::OP_TIMEOUT, random_byte());
   endtask

   task automatic send_frame(input int upto);
      for (int i = 0; i < upto && i < frame_q.size(); i++)
         send_request(rfd_pkg::OP_BYTE, frame_q[i]);
   endtask

   task automatic build_frame(input logic [7:0] status, input logic [15:0] announced,
                              input int body, input logic [31:0] flip);
      logic [31:0] crc;
      logic [7:0]  b;
      frame_q.delete();
      crc = '0;
      frame_q.push_back(rfd_pkg::MAGIC_FIRST);
      frame_q.push_back(rfd_pkg::MAGIC_SECOND);
      frame_q.push_back(status);
      frame_q.push_back(announced[15:8]);
      frame_q.push_back(announced[7:0]);
      for (int i = 2; i < 5; i++)
         crc = board.crc_step(crc, frame_q[i]);
      for (int i = 0; i < body; i++) begin
         b = random_byte();
         frame_q.push_back(b);
         crc = board.crc_step(crc, b);
      end
      crc = crc ^ flip;
      for (int i = 3; i >= 0; i--)
         frame_q.push_back(crc[8*i +: 8]);
   endtask

   task automatic configure(input logic [15:0] len_max, input logic [15:0] keep_max);
      csr_write <= 1'b1;
      csr_index <= rfd_pkg::CSR_MAX_LENGTH;
      csr_wdata <= len_max;
      @(negedge clock);
      csr_index <= rfd_pkg::CSR_REPLY_MAX;
      csr_wdata <= keep_max;
      @(negedge clock);
      csr_write <= 1'b0;
      board.set_limits(len_max, keep_max);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.replies_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic directed_frames();
      send_timeout();
      send_request(rfd_pkg::OP_BYTE, 8'h00);
      send_request(rfd_pkg::OP_TIMEOUT, 8'hff);
      send_request(rfd_pkg::OP_BYTE, rfd_pkg::MAGIC_FIRST);
      send_timeout();
      build_frame(8'h00, 16'hffff, 0, '0);
      send_frame(5);
      send_timeout();
      build_frame(8'hff, 16'h0000, 0, '0);
      send_frame(frame_q.size());
      build_frame(8'h5a, 16'h0000, 0, 32'h8000_0000);
      send_frame(frame_q.size());
      send_timeout();
   endtask

   function automatic int pick_length();
      int cap;
      int r;
      r   = $urandom_range(0, 99);
      cap = (r < 88) ? 12 : (r < 98) ? 80 : 300;
      if (board.length_limit < cap)
         cap = int'(board.length_limit);
      return $urandom_range(0, cap);
   endfunction

   task automatic random_frame();
      int         pick;
      int         len;
      int         cut;
      logic [7:0] status;
      logic [7:0] wrong;
      pick   = $urandom_range(0, 99);
      status = random_byte();
      if (pick < 55) begin
         len = pick_length();
         build_frame(status, 16'(len), len, '0);
         send_frame(frame_q.size());
         if ($urandom_range(0, 7) == 0)
            send_timeout();
      end else if (pick < 65) begin
         len = pick_length();
         build_frame(status, 16'(len), len, 32'h1 << $urandom_range(0, 31));
         repeat ($urandom_range(0, 3)) frame_q.push_back(random_byte());
         send_frame(frame_q.size());
         send_timeout();
      end else if (pick < 73) begin
         frame_q.delete();
         if ($urandom_range(0, 1) == 0) begin
            wrong = rfd_pkg::MAGIC_FIRST;
            while (wrong == rfd_pkg::MAGIC_FIRST) wrong = random_byte();
            frame_q.push_back(wrong);
         end else begin
            wrong = rfd_pkg::MAGIC_SECOND;
            while (wrong == rfd_pkg::MAGIC_SECOND) wrong = random_byte();
            frame_q.push_back(rfd_pkg::MAGIC_FIRST);
            frame_q.push_back(wrong);
         end
         repeat ($urandom_range(0, 5)) frame_q.push_back(random_byte());
         send_frame(frame_q.size());
         send_timeout();
      end else if (pick < 81 && board.length_limit != 16'hffff) begin
         len = $urandom_range(board.length_limit + 1, 65535);
         build_frame(status, 16'(len), $urandom_range(0, 4), '0);
         send_frame(frame_q.size());
         send_timeout();
      end else if (pick < 93) begin
         if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(0, board.length_limit);
            build_frame(status, 16'(len), (len < 6) ? len : 6, '0);
            cut = $urandom_range(1, frame_q.size() - 4);
         end else begin
            len = pick_length();
            build_frame(status, 16'(len), len, '0);
            cut = $urandom_range(1, frame_q.size() - 1);
         end
         send_frame(cut);
         send_timeout();
      end else if (pick < 97) begin
         send_timeout();
      end else begin
         frame_q.delete();
         repeat ($urandom_range(1, 6)) frame_q.push_back(random_byte());
         send_frame(frame_q.size());
         send_timeout();
      end
   endtask

   initial begin
      int start;
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = rfd_pkg::CSR_MAX_LENGTH;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_frames();
      drain();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: configure(16'hffff, 16'hffff);
            1: configure(16'h0000, 16'h0000);
            2: configure(16'd40, 16'd5);
            3: configure(16'hffff, 16'h0000);
            4: configure(16'd20, 16'hffff);
            5: configure(rfd_pkg::DEFAULT_LIMIT, rfd_pkg::DEFAULT_LIMIT);
            default: configure(16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
         endcase
         idling = (p % 3) != 2;
         if (p == 0)
            hold_request = 1'b1;
         start = sent_items;
         while (sent_items - start < PHASE_ITEMS) random_frame();
         drain();
      end

      repeat (8) @(negedge clock);
      if (board.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
